// ----- sv/npcm_pkg.sv -----
// Shared types, constants and helper functions for the nearest palette color mapper.
// Depends on nothing; every other file of the block refers to it by scoped names.
package npcm_pkg;

  // Default palette size and fixed field widths.
  localparam int PALETTE_ENTRIES_DEFAULT = 256;
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int RAW_W   = 32;
  localparam int DIST_W  = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // Color-key modes.
  localparam logic [1:0] KEY_NONE   = 2'd0;
  localparam logic [1:0] KEY_ALPHA  = 2'd1;
  localparam logic [1:0] KEY_SOURCE = 2'd2;
  localparam logic [1:0] KEY_AVOID  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_KEY   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_KEY = 2'd2;

  // Alpha below this value selects the destination key.
  localparam logic [CHAN_W-1:0] ALPHA_KEY_LIMIT = 8'd128;

  // Larger than any real squared distance (3 * 255 * 255).
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // One request as it travels down the chain of cells.
  typedef struct packed {
    logic               valid;
    logic               is_load;
    logic [INDEX_W-1:0] entry;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               keyed;
    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_idx;
  } npcm_item_t;

  // Absolute difference of two channel values.
  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Squared RGB distance between a pixel and a packed 24-bit palette color.
  function automatic logic [DIST_W-1:0] sq_dist(input logic [CHAN_W-1:0]   r,
                                                input logic [CHAN_W-1:0]   g,
                                                input logic [CHAN_W-1:0]   b,
                                                input logic [3*CHAN_W-1:0] color);
    logic [CHAN_W-1:0]   dr;
    logic [CHAN_W-1:0]   dg;
    logic [CHAN_W-1:0]   db;
    logic [2*CHAN_W-1:0] sr;
    logic [2*CHAN_W-1:0] sg;
    logic [2*CHAN_W-1:0] sb;
    dr = abs_diff(r, color[3*CHAN_W-1:2*CHAN_W]);
    dg = abs_diff(g, color[2*CHAN_W-1:CHAN_W]);
    db = abs_diff(b, color[CHAN_W-1:0]);
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  endfunction

endpackage

// ----- sv/npcm_if.sv -----
// Valid/ready channel interfaces for the nearest palette color mapper.
// Depends on npcm_pkg for the field widths.
interface npcm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [npcm_pkg::INDEX_W-1:0]     entry_index;
  logic [npcm_pkg::CHAN_W-1:0]      red;
  logic [npcm_pkg::CHAN_W-1:0]      green;
  logic [npcm_pkg::CHAN_W-1:0]      blue;
  logic [npcm_pkg::CHAN_W-1:0]      alpha;
  logic [npcm_pkg::RAW_W-1:0]       raw_pixel;

  modport source (output valid, op, entry_index, red, green, blue, alpha, raw_pixel,
                  input ready);
  modport sink (input valid, op, entry_index, red, green, blue, alpha, raw_pixel,
                output ready);
endinterface

interface npcm_out_if;
  logic                         valid;
  logic                         ready;
  logic [npcm_pkg::INDEX_W-1:0] palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink (input valid, palette_index, output ready);
endinterface

// ----- sv/npcm_fill.sv -----
// Palette fill tracker: one written flag per entry and a count of distinct entries.
// Depends on npcm_pkg.
module npcm_fill #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [npcm_pkg::INDEX_W-1:0] entry_index,
  output logic                         complete
);

  localparam int SEL_W   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COUNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [npcm_pkg::INDEX_W:0] ENTRY_LIMIT = (npcm_pkg::INDEX_W+1)'(PALETTE_ENTRIES);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(PALETTE_ENTRIES);

  logic [PALETTE_ENTRIES-1:0] written;
  logic [COUNT_W-1:0]         count;
  logic                       in_range;
  logic [SEL_W-1:0]           sel;

  assign in_range = {1'b0, entry_index} < ENTRY_LIMIT;
  assign sel      = entry_index[SEL_W-1:0];
  assign complete = (count == COUNT_FULL);

  // A first write to an entry sets its flag and bumps the count.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      count   <= '0;
    end else if (load && in_range && !written[sel]) begin
      written[sel] <= 1'b1;
      count        <= count + COUNT_W'(1);
    end
  end

endmodule

// ----- sv/npcm_cell.sv -----
// One palette cell: holds one palette color and refines the running nearest match
// of each pixel request passing through. Depends on npcm_pkg.
module npcm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  npcm_pkg::npcm_item_t link_in,
  output npcm_pkg::npcm_item_t link_out
);

  logic [3*npcm_pkg::CHAN_W-1:0] color;
  logic [npcm_pkg::DIST_W-1:0]   pix_dist;
  logic                          hit_load;
  npcm_pkg::npcm_item_t          link_next;

  assign hit_load = link_in.valid && link_in.is_load &&
                    (link_in.entry == npcm_pkg::INDEX_W'(CELL_INDEX));

  // Distance of the passing pixel to this cell's color; strict compare keeps the lower index on a tie.
  always_comb begin
    pix_dist  = npcm_pkg::sq_dist(link_in.red, link_in.green, link_in.blue, color);
    link_next = link_in;
    if (link_in.valid && !link_in.is_load && (pix_dist < link_in.best_dist)) begin
      link_next.best_dist = pix_dist;
      link_next.best_idx  = npcm_pkg::INDEX_W'(CELL_INDEX);
    end
  end

  // A load request for this entry replaces the color as it passes.
  always_ff @(posedge clk) begin
    if (adv && hit_load) begin
      color <= {link_in.red, link_in.green, link_in.blue};
    end
  end

  // Hand the request on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else if (adv) begin
      link_out <= link_next;
    end
  end

endmodule

// ----- sv/nearest_palette_color_mapper_top.sv -----
// Top level of the nearest palette color mapper: configuration registers, fill tracker,
// chain of palette cells and output register. Depends on npcm_pkg, npcm_if, npcm_fill, npcm_cell.
//
// Usage:
//   Requests arrive on the pixel channel (valid/ready). op = load writes one palette
//   entry; op = map asks for the nearest palette index of a pixel. Results leave on
//   the result channel, one per mapped pixel; loads and pixels that arrive before
//   every palette entry has been written give no result.
//   Each request walks a chain of PALETTE_ENTRIES cells, one cell per cycle while the chain
//   advances, and then the output register before its result appears.
//   Throughput is one request per cycle while the result channel does not stall; the chain
//   shifts as a whole, with the distance and compare done combinationally inside each cell.
//   Loads travel the chain like pixels, so a load takes effect for exactly the
//   pixels that follow it.
//   When the receiver stalls with a result waiting, the whole chain holds and ready
//   on the pixel channel drops until the result is taken.
//   Reset clears the configuration registers, the written flags and all valid bits;
//   palette colors hold no value until loaded. Configuration writes (cfg_we,
//   cfg_index, cfg_data) are taken in any cycle and are meant for an idle block.
module nearest_palette_color_mapper_top #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [npcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  npcm_in_if.sink                          pixel,
  npcm_out_if.source                       result
);

  logic [1:0]                   key_mode;
  logic [npcm_pkg::INDEX_W-1:0] dest_key;
  logic [npcm_pkg::RAW_W-1:0]   source_key;

  logic                         adv;
  logic                         accept;
  logic                         complete;
  logic                         keyed;
  logic                         out_valid;
  logic [npcm_pkg::INDEX_W-1:0] out_index;
  logic [npcm_pkg::INDEX_W-1:0] found;
  npcm_pkg::npcm_item_t         link [PALETTE_ENTRIES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode   <= npcm_pkg::KEY_NONE;
      dest_key   <= '0;
      source_key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        npcm_pkg::REG_KEY_MODE:   key_mode   <= cfg_data[1:0];
        npcm_pkg::REG_DEST_KEY:   dest_key   <= cfg_data[npcm_pkg::INDEX_W-1:0];
        npcm_pkg::REG_SOURCE_KEY: source_key <= cfg_data[npcm_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  assign adv          = !out_valid || result.ready;
  assign pixel.ready  = adv;
  assign accept       = pixel.valid && adv;

  npcm_fill #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_fill (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && (pixel.op == npcm_pkg::OP_LOAD)),
    .entry_index (pixel.entry_index),
    .complete    (complete)
  );

  // Key decision is made on entry so alpha and the raw word need not travel.
  assign keyed = ((key_mode == npcm_pkg::KEY_ALPHA) &&
                  (pixel.alpha < npcm_pkg::ALPHA_KEY_LIMIT)) ||
                 ((key_mode == npcm_pkg::KEY_SOURCE) && (pixel.raw_pixel == source_key));

  // Head of the chain; pixels ahead of a full palette enter as bubbles.
  always_comb begin
    link[0].valid     = pixel.valid && ((pixel.op == npcm_pkg::OP_LOAD) || complete);
    link[0].is_load   = (pixel.op == npcm_pkg::OP_LOAD);
    link[0].entry     = pixel.entry_index;
    link[0].red       = pixel.red;
    link[0].green     = pixel.green;
    link[0].blue      = pixel.blue;
    link[0].keyed     = keyed;
    link[0].best_dist = npcm_pkg::DIST_MAX;
    link[0].best_idx  = '0;
  end

  // Chain of palette cells.
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  // Final key substitution or key avoidance.
  always_comb begin
    if (link[PALETTE_ENTRIES].keyed) begin
      found = dest_key;
    end else if ((key_mode != npcm_pkg::KEY_NONE) &&
                 (link[PALETTE_ENTRIES].best_idx == dest_key)) begin
      found = link[PALETTE_ENTRIES].best_idx ^ npcm_pkg::INDEX_W'(1);
    end else begin
      found = link[PALETTE_ENTRIES].best_idx;
    end
  end

  // Output register; only pixel requests leave a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= link[PALETTE_ENTRIES].valid && !link[PALETTE_ENTRIES].is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index <= found;
    end
  end

  assign result.valid         = out_valid;
  assign result.palette_index = out_index;

`ifndef NO_ASSERTIONS
  // Once the palette is full it stays full.
  assert property (@(posedge clk) disable iff (rst) complete |=> complete)
    else $error("palette fill state fell back to incomplete");

  // A pixel in the chain was admitted only with a full palette.
  assert property (@(posedge clk) disable iff (rst)
    (link[1].valid && !link[1].is_load) |-> complete)
    else $error("pixel entered the chain before the palette was full");

  // A stall freezes the last stage of the chain.
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(link[PALETTE_ENTRIES]))
    else $error("chain moved while the result was stalled");
`endif

endmodule

// ----- tb/sv/tb_nearest_palette_color_mapper_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_palette_color_mapper_top: directed tests, then
// random traffic, mostly with idling on both channels. Depends on npcm_pkg, npcm_if and the top.
module tb_nearest_palette_color_mapper_top;

  localparam int PAL_SIZE     = npcm_pkg::PALETTE_ENTRIES_DEFAULT;
  localparam int PIPE_LATENCY = PAL_SIZE + 1;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int CW           = npcm_pkg::CHAN_W;
  localparam int IW           = npcm_pkg::INDEX_W;
  localparam int RW           = npcm_pkg::RAW_W;
  localparam int CIW          = npcm_pkg::CFG_INDEX_W;
  localparam int CDW          = npcm_pkg::CFG_DATA_W;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CIW-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;

  npcm_in_if  pixel_ch ();
  npcm_out_if result_ch ();

  nearest_palette_color_mapper_top #(
    .PALETTE_ENTRIES(PAL_SIZE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixel_ch),
    .result(result_ch)
  );

  // Palette contents and key registers as the block should hold them.
  logic [3*CW-1:0] palette_color [PAL_SIZE];
  bit              entry_loaded [PAL_SIZE];
  int              loaded_count;
  logic [1:0]      key_mode_cfg;
  logic [IW-1:0]   dest_key_cfg;
  logic [RW-1:0]   source_key_cfg;

  // Palette indexes still owed by the block, oldest first.
  logic [IW-1:0] expected_index_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int cycle_count;
  int mode_turn;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d results outstanding",
               CYCLE_LIMIT, expected_index_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Each accepted result is compared with the oldest expected index.
  always @(posedge clk) begin : check_results
    logic [IW-1:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_index_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no pixel outstanding",
                                  result_ch.palette_index));
      end else begin
        want = expected_index_q.pop_front();
        if (result_ch.palette_index !== want)
          report_mismatch($sformatf("palette_index %0d, expected %0d",
                                    result_ch.palette_index, want));
      end
    end
  end

  // Exhaustive search for the closest palette color; strict compare keeps the lowest
  // index on a tie.
  function automatic logic [IW-1:0] nearest_entry_index(input logic [CW-1:0] r,
                                                        input logic [CW-1:0] g,
                                                        input logic [CW-1:0] b);
    int i;
    int dr;
    int dg;
    int db;
    int sq_sum;
    int best_dist;
    logic [IW-1:0] best_idx;
    best_dist = 32'h7fff_ffff;
    best_idx  = '0;
    for (i = 0; i < PAL_SIZE; i++) begin
      dr = int'(r) - int'(palette_color[i][23:16]);
      dg = int'(g) - int'(palette_color[i][15:8]);
      db = int'(b) - int'(palette_color[i][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best_idx  = IW'(i);
      end
    end
    return best_idx;
  endfunction

  // Applies one accepted request: a load updates the palette, a pixel on a full
  // palette owes one index.
  function automatic void update_palette_and_predict(input logic op,
                                                     input logic [IW-1:0] entry,
                                                     input logic [3*CW-1:0] color,
                                                     input logic [CW-1:0] alpha,
                                                     input logic [RW-1:0] raw);
    logic [IW-1:0] idx;
    if (op == npcm_pkg::OP_LOAD) begin
      palette_color[entry] = color;
      if (!entry_loaded[entry]) begin
        entry_loaded[entry] = 1'b1;
        loaded_count++;
      end
      return;
    end
    if (loaded_count < PAL_SIZE)
      return;
    if ((key_mode_cfg == npcm_pkg::KEY_ALPHA && alpha < npcm_pkg::ALPHA_KEY_LIMIT) ||
        (key_mode_cfg == npcm_pkg::KEY_SOURCE && raw == source_key_cfg)) begin
      idx = dest_key_cfg;
    end else begin
      idx = nearest_entry_index(color[23:16], color[15:8], color[7:0]);
      if (key_mode_cfg != npcm_pkg::KEY_NONE && idx == dest_key_cfg)
        idx[0] = ~idx[0];
    end
    expected_index_q.push_back(idx);
  endfunction

  // Sends one request, idling first at random, and records it once accepted.
  task automatic send_request(input logic op, input logic [IW-1:0] entry,
                              input logic [3*CW-1:0] color,
                              input logic [CW-1:0] alpha,
                              input logic [RW-1:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.op          <= op;
    pixel_ch.entry_index <= entry;
    pixel_ch.red         <= color[23:16];
    pixel_ch.green       <= color[15:8];
    pixel_ch.blue        <= color[7:0];
    pixel_ch.alpha       <= alpha;
    pixel_ch.raw_pixel   <= raw;
    do @(posedge clk); while (!pixel_ch.ready);
    update_palette_and_predict(op, entry, color, alpha, raw);
  endtask

  task automatic load_entry(input int entry, input logic [3*CW-1:0] color);
    send_request(npcm_pkg::OP_LOAD, IW'(entry), color, CW'($urandom), $urandom);
  endtask

  task automatic map_pixel(input logic [3*CW-1:0] color, input logic [CW-1:0] alpha,
                           input logic [RW-1:0] raw);
    send_request(npcm_pkg::OP_MAP, IW'($urandom), color, alpha, raw);
  endtask

  // Stops sending and waits for every owed result.
  task automatic wait_for_results();
    pixel_ch.valid <= 1'b0;
    while (expected_index_q.size() != 0)
      @(posedge clk);
  endtask

  // Loads and dropped pixels give no result, so allow one full pass of the chain too.
  task automatic drain_pipeline();
    wait_for_results();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CIW-1:0] idx,
                                input logic [CDW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      npcm_pkg::REG_KEY_MODE:   key_mode_cfg   = value[1:0];
      npcm_pkg::REG_DEST_KEY:   dest_key_cfg   = value[IW-1:0];
      npcm_pkg::REG_SOURCE_KEY: source_key_cfg = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [IW-1:0] dkey,
                           input logic [RW-1:0] skey);
    drain_pipeline();
    write_register(npcm_pkg::REG_KEY_MODE, CDW'(mode));
    write_register(npcm_pkg::REG_DEST_KEY, CDW'(dkey));
    write_register(npcm_pkg::REG_SOURCE_KEY, skey);
  endtask

  task automatic load_gray_palette(input int first, input int last);
    int i;
    for (i = first; i <= last; i++)
      load_entry(i, {3{CW'(i)}});
  endtask

  // Pixels sent while entries are still missing, a rewrite among them, give nothing.
  task automatic test_incomplete_palette();
    map_pixel(24'h102030, 8'hff, 32'h0);
    load_gray_palette(0, PAL_SIZE - 2);
    load_entry(0, 24'h000000);
    map_pixel(24'h000000, 8'h00, 32'h0);
    map_pixel(24'hffffff, 8'hff, 32'hffff_ffff);
  endtask

  // Reset configuration: no key. Extremes and both kinds of tie.
  task automatic test_nearest_search();
    load_gray_palette(PAL_SIZE - 1, PAL_SIZE - 1);
    load_entry(100, 24'h323232);
    load_entry(3, 24'hff0000);
    load_entry(4, 24'hff0002);
    map_pixel(24'h000000, 8'h00, 32'h0);
    map_pixel(24'hffffff, 8'hff, 32'hffff_ffff);
    map_pixel(24'h323232, 8'h80, 32'h1234_5678);
    map_pixel(24'hff0001, 8'h7f, 32'h0);
    map_pixel(24'h8040c8, 8'h40, 32'h8000_0001);
  endtask

  task automatic test_alpha_key();
    configure(npcm_pkg::KEY_ALPHA, 8'hff, 32'hffff_ffff);
    map_pixel(24'h202020, 8'd127, 32'h0);
    map_pixel(24'hffffff, 8'd128, 32'h0);
    map_pixel(24'h606060, 8'd0, 32'hffff_ffff);
    map_pixel(24'h000000, 8'd255, 32'h0);
  endtask

  task automatic test_source_key();
    configure(npcm_pkg::KEY_SOURCE, 8'h00, 32'hffff_ffff);
    map_pixel(24'h909090, 8'hff, 32'hffff_ffff);
    map_pixel(24'h000000, 8'hff, 32'hffff_fffe);
    map_pixel(24'h070707, 8'h00, 32'h0);
    map_pixel(24'h0a0b0c, 8'h00, 32'h7fff_ffff);
  endtask

  // Only avoidance: the source key and alpha are ignored.
  task automatic test_key_avoidance();
    configure(npcm_pkg::KEY_AVOID, 8'd50, 32'h0);
    map_pixel(24'h323232, 8'hff, 32'h1);
    map_pixel(24'h090909, 8'hff, 32'h0);
    map_pixel(24'hc8c8c8, 8'h00, 32'hdead_beef);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [RW-1:0] pick_source_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic in two settings, mostly pixels, some aimed at the key entry.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count,
                                     input bit pause_midway);
    int half;
    int n;
    logic [3*CW-1:0] color;
    logic [RW-1:0] raw;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (half = 0; half < 2; half++) begin
      configure(2'(mode_turn), pick_byte(), pick_source_key());
      mode_turn++;
      for (n = 0; n < count / 2; n++) begin
        if (pause_midway && half == 1 && n == count / 4)
          wait_for_results();
        if ($urandom_range(0, 99) < 15) begin
          load_entry($urandom_range(0, PAL_SIZE - 1), 24'($urandom));
        end else begin
          case ($urandom_range(0, 9))
            0, 1: color = palette_color[dest_key_cfg];
            2:    color = palette_color[$urandom_range(0, PAL_SIZE - 1)];
            default: color = 24'($urandom);
          endcase
          raw = ($urandom_range(0, 3) == 0) ? source_key_cfg : $urandom;
          map_pixel(color, 8'($urandom), raw);
        end
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    pixel_ch.valid        = 1'b0;
    pixel_ch.op           = npcm_pkg::OP_LOAD;
    pixel_ch.entry_index  = '0;
    pixel_ch.red          = '0;
    pixel_ch.green        = '0;
    pixel_ch.blue         = '0;
    pixel_ch.alpha        = '0;
    pixel_ch.raw_pixel    = '0;
    result_ch.ready       = 1'b0;
    send_idle_pct         = 38;
    recv_idle_pct         = 64;
    mismatch_count        = 0;
    cycle_count           = 0;
    mode_turn             = 0;
    loaded_count          = 0;
    key_mode_cfg          = npcm_pkg::KEY_NONE;
    dest_key_cfg          = '0;
    source_key_cfg        = '0;
    for (int i = 0; i < PAL_SIZE; i++) begin
      palette_color[i] = '0;
      entry_loaded[i]  = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_incomplete_palette();
    test_nearest_search();
    test_alpha_key();
    test_source_key();
    test_key_avoidance();
    test_random_traffic(38, 64, 40, 1'b0);
    test_random_traffic(64, 38, 40, 1'b0);
    test_random_traffic(0, 0, 40, 1'b1);

    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/npcm_pkg.sv
sv/npcm_if.sv
sv/npcm_fill.sv
sv/npcm_cell.sv
sv/nearest_palette_color_mapper_top.sv
tb/sv/tb_nearest_palette_color_mapper_top.sv
